// ----- src/dfst_pkg.sv -----
// ---------------------------------------------------------------------------
// dfst_pkg: shared constants and types for the depth-first search block
// Holds the configuration defaults, the command codes and the state encoding.
// ---------------------------------------------------------------------------
`default_nettype none

package dfst_pkg;

  // Default number of vertex slots in the adjacency store.
  localparam int DefaultMaxVertices = 16;

  // Fixed widths of the interface fields.
  localparam int CountWidth = 5;
  localparam int RowIndexWidth = 4;
  localparam int RowBitsWidth = 16;
  localparam int VertexWidth = 4;
  localparam int StampWidth = 6;

  // Vertex count after reset.
  localparam logic [CountWidth-1:0] CountReset = 5'd16;

  // Command codes of an input item.
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_RUN  = 1'b1
  } cmd_e;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ROOT    = 6'b000010,
    ST_SCAN    = 6'b000100,
    ST_POP     = 6'b001000,
    ST_EM_READ = 6'b010000,
    ST_EM_LOAD = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ----- src/dfs_discovery_finish_times.sv -----
// ---------------------------------------------------------------------------
// dfs_discovery_finish_times: depth-first search with discovery and finish
// timestamps over a small directed graph held as an adjacency matrix.
// ---------------------------------------------------------------------------
// Usage. Items enter on the input channel (in_valid_i / in_stall_o) and
// results leave on the output channel (out_valid_o / out_stall_i). A load item
// (command 0) writes one adjacency row and gives no result.
// A run item (command 1) walks the graph and then delivers one result per
// vertex in use, in vertex order, with last_o set on the final one. A run
// with a vertex count of zero gives no result.
// A run reads the adjacency memory one row per cycle while the current
// vertex's neighbors are scanned, pausing in each cycle that discovers a
// neighbor; each result is read from the stamp memories and then loaded into
// the output register. The block takes a new item only while the sequencer is idle.
// The vertex count register is written through cfg_we_i / cfg_wdata_i; the
// user must do so only while the block is idle, which the block does not
// enforce. Values above MAX_VERTICES act as MAX_VERTICES. Reset clears the
// adjacency store row by row before the first item and sets the count to 16.
// When the receiver stalls, the finished result holds in the output register
// and the sequencer waits before it loads the next one.
// ---------------------------------------------------------------------------
`default_nettype none

module dfs_discovery_finish_times #(
  parameter int MAX_VERTICES = dfst_pkg::DefaultMaxVertices
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [dfst_pkg::CountWidth-1:0]        cfg_wdata_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   command_i,
  input  wire logic [dfst_pkg::RowIndexWidth-1:0]     row_index_i,
  input  wire logic [dfst_pkg::RowBitsWidth-1:0]      row_bits_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [dfst_pkg::VertexWidth-1:0]            vertex_o,
  output logic [dfst_pkg::StampWidth-1:0]             reach_time_o,
  output logic [dfst_pkg::StampWidth-1:0]             finish_time_o,
  output logic                                        last_o
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = VW + 1;
  localparam int SW = dfst_pkg::StampWidth;
  localparam int RW = dfst_pkg::RowBitsWidth;
  localparam logic [5:0] MaxV6 = 6'(MAX_VERTICES);
  localparam logic [NW-1:0] MaxN = NW'(MAX_VERTICES);

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic [NW-1:0] next;
  } stack_entry_t;

  // Memories.
  logic [RW-1:0]     adj_mem  [MAX_VERTICES];
  logic [SW-1:0]     disc_mem [MAX_VERTICES];
  logic [SW-1:0]     fin_mem  [MAX_VERTICES];
  stack_entry_t      stk_mem  [MAX_VERTICES];

  // Control registers.
  dfst_pkg::state_e         state_q, state_d;
  logic [dfst_pkg::CountWidth-1:0] count_q;
  logic [SW-1:0]            clock_q, clock_d;
  logic [VW-1:0]            sp_q, sp_d;
  logic [VW-1:0]            cur_v_q, cur_v_d;
  logic [NW-1:0]            scan_u_q, scan_u_d;
  logic                     rd_valid_q, rd_valid_d;
  logic [VW-1:0]            rd_u_q, rd_u_d;
  logic [NW-1:0]            root_q, root_d;
  logic [NW-1:0]            em_q, em_d;
  logic [NW-1:0]            n_q, n_d;
  logic [MAX_VERTICES-1:0]  visited_q, visited_d;
  logic                     out_valid_q, out_valid_d;
  logic                     clearing_q;
  logic [NW-1:0]            clr_q;

  // Output payload registers.
  logic [dfst_pkg::VertexWidth-1:0] out_vertex_q;
  logic [SW-1:0]            out_reach_q, out_finish_q;
  logic                     out_last_q;
  logic                     out_load;

  // Memory ports.
  logic                     adj_we, adj_re;
  logic [VW-1:0]            adj_waddr, adj_raddr;
  logic [RW-1:0]            adj_wdata, adj_rd_q;
  logic                     disc_we, fin_we, stamp_re;
  logic [VW-1:0]            disc_waddr;
  logic [SW-1:0]            disc_rd_q, fin_rd_q;
  logic                     stk_we, stk_re;
  logic [VW-1:0]            stk_raddr;
  stack_entry_t             stk_wdata, stk_rd_q;

  // Scan helpers.
  logic [4:0]               v5;
  logic                     adj_bit;
  logic                     hit;
  logic [5:0]               n6;
  logic                     in_accept;
  logic                     out_free;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Effective vertex count, clamped to the store size.
  assign n6 = ({1'b0, count_q} > MaxV6) ? MaxV6 : {1'b0, count_q};

  // The neighbor test reads bit cur_v of the row fetched last cycle; rows
  // carry 16 bits, so vertices above 15 never have a listed neighbor.
  assign v5      = 5'(cur_v_q);
  assign adj_bit = !v5[4] && adj_rd_q[v5[3:0]];
  assign hit     = rd_valid_q && adj_bit && !visited_q[rd_u_q];

  always_comb begin
    state_d     = state_q;
    clock_d     = clock_q;
    sp_d        = sp_q;
    cur_v_d     = cur_v_q;
    scan_u_d    = scan_u_q;
    rd_valid_d  = 1'b0;
    rd_u_d      = rd_u_q;
    root_d      = root_q;
    em_d        = em_q;
    n_d         = n_q;
    visited_d   = visited_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    adj_we      = 1'b0;
    adj_waddr   = VW'(row_index_i);
    adj_wdata   = row_bits_i;
    adj_re      = 1'b0;
    adj_raddr   = scan_u_q[VW-1:0];
    disc_we     = 1'b0;
    disc_waddr  = cur_v_q;
    fin_we      = 1'b0;
    stamp_re    = 1'b0;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_raddr   = sp_q - VW'(1);
    stk_wdata   = '{vertex: cur_v_q, next: NW'(rd_u_q) + NW'(1)};
    in_stall_o  = 1'b1;

    // The reset sweep clears one adjacency row per cycle.
    if (clearing_q) begin
      adj_we    = 1'b1;
      adj_waddr = clr_q[VW-1:0];
      adj_wdata = '0;
    end

    case (state_q)
      dfst_pkg::ST_IDLE: begin
        in_stall_o = clearing_q;
        if (in_accept) begin
          if (command_i == dfst_pkg::CMD_LOAD) begin
            adj_we = (6'(row_index_i) < MaxV6);
          end else begin
            clock_d   = '0;
            sp_d      = '0;
            visited_d = '0;
            root_d    = '0;
            n_d       = n6[NW-1:0];
            state_d   = dfst_pkg::ST_ROOT;
          end
        end
      end

      dfst_pkg::ST_ROOT: begin
        if (root_q >= n_q) begin
          em_d    = '0;
          state_d = (n_q == '0) ? dfst_pkg::ST_IDLE : dfst_pkg::ST_EM_READ;
        end else begin
          root_d = root_q + NW'(1);
          if (!visited_q[root_q[VW-1:0]]) begin
            clock_d    = clock_q + SW'(1);
            disc_we    = 1'b1;
            disc_waddr = root_q[VW-1:0];
            visited_d[root_q[VW-1:0]] = 1'b1;
            cur_v_d    = root_q[VW-1:0];
            scan_u_d   = '0;
            state_d    = dfst_pkg::ST_SCAN;
          end
        end
      end

      dfst_pkg::ST_SCAN: begin
        if (hit) begin
          // Discover the neighbor: save the parent and where its scan resumes.
          clock_d    = clock_q + SW'(1);
          disc_we    = 1'b1;
          disc_waddr = rd_u_q;
          visited_d[rd_u_q] = 1'b1;
          stk_we     = 1'b1;
          sp_d       = sp_q + VW'(1);
          cur_v_d    = rd_u_q;
          scan_u_d   = '0;
        end else if (scan_u_q >= n_q && !rd_valid_q) begin
          // No white neighbor left: the vertex finishes.
          clock_d = clock_q + SW'(1);
          fin_we  = 1'b1;
          if (sp_q == '0) begin
            state_d = dfst_pkg::ST_ROOT;
          end else begin
            stk_re  = 1'b1;
            sp_d    = sp_q - VW'(1);
            state_d = dfst_pkg::ST_POP;
          end
        end else if (scan_u_q < n_q) begin
          adj_re     = 1'b1;
          rd_valid_d = 1'b1;
          rd_u_d     = scan_u_q[VW-1:0];
          scan_u_d   = scan_u_q + NW'(1);
        end
      end

      dfst_pkg::ST_POP: begin
        cur_v_d  = stk_rd_q.vertex;
        scan_u_d = stk_rd_q.next;
        state_d  = dfst_pkg::ST_SCAN;
      end

      dfst_pkg::ST_EM_READ: begin
        stamp_re = 1'b1;
        state_d  = dfst_pkg::ST_EM_LOAD;
      end

      dfst_pkg::ST_EM_LOAD: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          em_d        = em_q + NW'(1);
          state_d     = ((em_q + NW'(1)) == n_q) ? dfst_pkg::ST_IDLE
                                                  : dfst_pkg::ST_EM_READ;
        end
      end

      default: begin
        state_d = dfst_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dfst_pkg::ST_IDLE;
      count_q     <= dfst_pkg::CountReset;
      clock_q     <= '0;
      sp_q        <= '0;
      cur_v_q     <= '0;
      scan_u_q    <= '0;
      rd_valid_q  <= 1'b0;
      rd_u_q      <= '0;
      root_q      <= '0;
      em_q        <= '0;
      n_q         <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      clock_q     <= clock_d;
      sp_q        <= sp_d;
      cur_v_q     <= cur_v_d;
      scan_u_q    <= scan_u_d;
      rd_valid_q  <= rd_valid_d;
      rd_u_q      <= rd_u_d;
      root_q      <= root_d;
      em_q        <= em_d;
      n_q         <= n_d;
      visited_q   <= visited_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (clearing_q) begin
        clr_q <= clr_q + NW'(1);
        if (clr_q == MaxN - NW'(1)) begin
          clearing_q <= 1'b0;
        end
      end
    end
  end

  // Output payload registers.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_vertex_q <= dfst_pkg::VertexWidth'(em_q[VW-1:0]);
      out_reach_q  <= disc_rd_q;
      out_finish_q <= fin_rd_q;
      out_last_q   <= ((em_q + NW'(1)) == n_q);
    end
  end

  // Adjacency memory.
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rd_q <= adj_mem[adj_raddr];
    end
  end

  // Discovery and finish stamp memories.
  always_ff @(posedge clk_i) begin
    if (disc_we) begin
      disc_mem[disc_waddr] <= clock_d;
    end
    if (fin_we) begin
      fin_mem[cur_v_q] <= clock_d;
    end
    if (stamp_re) begin
      disc_rd_q <= disc_mem[em_q[VW-1:0]];
      fin_rd_q  <= fin_mem[em_q[VW-1:0]];
    end
  end

  // Walk stack memory.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[sp_q] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_o      = out_vertex_q;
  assign reach_time_o  = out_reach_q;
  assign finish_time_o = out_finish_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire
